// ===== hw/rtl/fdas_pkg.sv =====
`default_nettype none

package fdas_pkg;

    // Pressure lanes and fall counter size.
    localparam int PRESSURE_CHANNELS = 8;
    localparam int COUNTER_BITS      = 8;

    // Foot pressure channels: 12 bits each, four per foot.
    localparam int CHAN_W      = 12;
    localparam int FOOT_W      = 48;
    localparam int SUM_W       = CHAN_W + $clog2(PRESSURE_CHANNELS);

    // Weight filter, kg * 65536.
    localparam int WEIGHT_W    = 24;
    localparam int ACC_W       = 41;
    localparam int FILT_SHIFT  = 16;
    localparam int KG_SHIFT    = 8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 24'd327680;
    localparam logic [15:0] KEEP_GAIN = 16'd52429;
    localparam logic [13:0] NEW_GAIN  = 14'd13107;

    // Angle prediction, rad * 4096 * 1024.
    localparam int ANGLE_W     = 16;
    localparam int LOOK_W      = 10;
    localparam int LOOK_SHIFT  = 10;
    localparam int FUT_W       = ANGLE_W + LOOK_W + 1;
    localparam int FUT_CMP_W   = FUT_W + 1;
    localparam int ANG_CMP_W   = ANGLE_W + 1;

    // Configuration field widths.
    localparam int THR_W       = 15;
    localparam int CONF_W      = 8;
    localparam int MODE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    localparam int MODE_BYPASS = 0;
    localparam int MODE_GETUP  = 1;
    localparam int MODE_UKEMI  = 2;

    // Counter widths for compare and for the reported count.
    localparam int CNT_OUT_W   = 8;
    localparam int CNT_CMP_W   = (COUNTER_BITS > CONF_W) ? COUNTER_BITS : CONF_W;

    // Action codes.
    localparam int ACT_W = 6;
    localparam logic [ACT_W-1:0] ACT_CALIBRATE    = 6'd1;
    localparam logic [ACT_W-1:0] ACT_GOALIE_STAND = 6'd2;
    localparam logic [ACT_W-1:0] ACT_GETUP_BACK   = 6'd3;
    localparam logic [ACT_W-1:0] ACT_GETUP_FRONT  = 6'd4;
    localparam logic [ACT_W-1:0] ACT_UNSTIFF      = 6'd5;
    localparam logic [ACT_W-1:0] ACT_TIP_OVER     = 6'd6;
    localparam logic [ACT_W-1:0] ACT_UKEMI_FRONT  = 6'd7;
    localparam logic [ACT_W-1:0] ACT_UKEMI_BACK   = 6'd8;
    localparam logic [ACT_W-1:0] ACT_PICKUP       = 6'd9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FALLEN     = 3'd0,
        CFG_FWD        = 3'd1,
        CFG_BACK       = 3'd2,
        CFG_SIDE       = 3'd3,
        CFG_LOOK       = 3'd4,
        CFG_MIN_WEIGHT = 3'd5,
        CFG_CONFIRM    = 3'd6,
        CFG_MODE       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [FOOT_W-1:0]         left_foot_pressures;
        logic [FOOT_W-1:0]         right_foot_pressures;
        logic                      pressures_valid;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] roll_rate;
        logic signed [ANGLE_W-1:0] pitch_rate;
        logic [ACT_W-1:0]          requested_action;
    } t_in_word;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic                 overridden;
        logic [CNT_OUT_W-1:0] falling_count;
    } t_out_word;

    // What one axis lane found.
    typedef struct packed {
        logic fallen_hi;
        logic fallen_lo;
        logic ahead_hi;
        logic ahead_lo;
    } t_lane_flags;

    // Pipeline controls for the weight filter.
    typedef struct packed {
        logic in_load;
        logic prod_load;
        logic commit;
        logic update;
    } t_weight_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/fdas_lane.sv =====
`default_nettype none

// One axis: registers the angle and its predicted value, then compares both
// against the fallen limit and the two prediction limits.
module fdas_lane (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_load,
    input  wire logic signed [fdas_pkg::ANGLE_W-1:0]  i_angle,
    input  wire logic signed [fdas_pkg::ANGLE_W-1:0]  i_rate,
    input  wire logic [fdas_pkg::LOOK_W-1:0]          i_look,
    input  wire logic [fdas_pkg::THR_W-1:0]           i_fallen_thr,
    input  wire logic [fdas_pkg::THR_W-1:0]           i_hi_thr,
    input  wire logic [fdas_pkg::THR_W-1:0]           i_lo_thr,
    output fdas_pkg::t_lane_flags                     o_flags
);

    logic signed [fdas_pkg::FUT_W-1:0]     w_angle_ext;
    logic signed [fdas_pkg::FUT_W-1:0]     w_rate_ext;
    logic signed [fdas_pkg::FUT_W-1:0]     w_look_ext;
    logic signed [fdas_pkg::FUT_W-1:0]     n_future;
    logic signed [fdas_pkg::FUT_W-1:0]     r_future;
    logic signed [fdas_pkg::ANGLE_W-1:0]   r_angle;
    logic signed [fdas_pkg::ANG_CMP_W-1:0] w_angle_cmp;
    logic signed [fdas_pkg::ANG_CMP_W-1:0] w_fallen;
    logic signed [fdas_pkg::FUT_CMP_W-1:0] w_future_cmp;
    logic signed [fdas_pkg::FUT_CMP_W-1:0] w_hi;
    logic signed [fdas_pkg::FUT_CMP_W-1:0] w_lo;

    // Future angle scaled by 1024: angle * 1024 + rate * lookahead, exact.
    always_comb begin
        w_angle_ext = fdas_pkg::FUT_W'(i_angle);
        w_rate_ext  = fdas_pkg::FUT_W'(i_rate);
        w_look_ext  = $signed(fdas_pkg::FUT_W'(i_look));
        n_future    = (w_angle_ext <<< fdas_pkg::LOOK_SHIFT) + w_rate_ext * w_look_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_angle  <= i_angle;
            r_future <= n_future;
        end
    end

    always_comb begin
        w_angle_cmp  = fdas_pkg::ANG_CMP_W'(r_angle);
        w_fallen     = $signed(fdas_pkg::ANG_CMP_W'(i_fallen_thr));
        w_future_cmp = fdas_pkg::FUT_CMP_W'(r_future);
        w_hi = $signed(fdas_pkg::FUT_CMP_W'({i_hi_thr, {fdas_pkg::LOOK_SHIFT{1'b0}}}));
        w_lo = $signed(fdas_pkg::FUT_CMP_W'({i_lo_thr, {fdas_pkg::LOOK_SHIFT{1'b0}}}));
        o_flags.fallen_hi = w_angle_cmp > w_fallen;
        o_flags.fallen_lo = w_angle_cmp < -w_fallen;
        o_flags.ahead_hi  = w_future_cmp > w_hi;
        o_flags.ahead_lo  = w_future_cmp < -w_lo;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fdas_weight.sv =====
`default_nettype none

// Pressure lanes summed into a registered total, then the first-order weight
// filter: products in one stage, add and commit in the next.
module fdas_weight (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire fdas_pkg::t_weight_ctl            i_ctl,
    input  wire logic [fdas_pkg::FOOT_W-1:0]      i_left,
    input  wire logic [fdas_pkg::FOOT_W-1:0]      i_right,
    input  wire logic [fdas_pkg::THR_W-1:0]       i_min_weight,
    output logic                                  o_lifted
);

    logic [2*fdas_pkg::FOOT_W-1:0] w_all;
    logic [fdas_pkg::SUM_W-1:0]    n_sum;
    logic [fdas_pkg::SUM_W-1:0]    r_sum;
    logic [fdas_pkg::ACC_W-1:0]    r_p_keep;
    logic [fdas_pkg::ACC_W-1:0]    r_p_new;
    logic [fdas_pkg::ACC_W-1:0]    w_acc;
    logic [fdas_pkg::WEIGHT_W-1:0] r_fw;
    logic [fdas_pkg::WEIGHT_W-1:0] n_fw;

    assign w_all = {i_right, i_left};

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < fdas_pkg::PRESSURE_CHANNELS; k++) begin
            n_sum = n_sum + fdas_pkg::SUM_W'(w_all[fdas_pkg::CHAN_W*k +: fdas_pkg::CHAN_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.in_load) begin
            r_sum <= n_sum;
        end
        if (i_ctl.prod_load) begin
            r_p_keep <= fdas_pkg::ACC_W'(r_fw) * fdas_pkg::ACC_W'(fdas_pkg::KEEP_GAIN);
            r_p_new  <= fdas_pkg::ACC_W'({r_sum, {fdas_pkg::KG_SHIFT{1'b0}}})
                        * fdas_pkg::ACC_W'(fdas_pkg::NEW_GAIN);
        end
    end

    always_comb begin
        w_acc = r_p_keep + r_p_new;
        n_fw  = i_ctl.update ? w_acc[fdas_pkg::FILT_SHIFT +: fdas_pkg::WEIGHT_W] : r_fw;
        o_lifted = n_fw < fdas_pkg::WEIGHT_W'({i_min_weight, {fdas_pkg::KG_SHIFT{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= fdas_pkg::WEIGHT_RESET;
        end else if (i_ctl.commit) begin
            r_fw <= n_fw;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fdas_select.sv =====
`default_nettype none

// Merge stage: walks the checks in priority order and keeps the fall counter.
module fdas_select (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_commit,
    input  wire logic [fdas_pkg::ACT_W-1:0]       i_req,
    input  wire logic [fdas_pkg::MODE_W-1:0]      i_mode,
    input  wire logic [fdas_pkg::CONF_W-1:0]      i_conf,
    input  wire fdas_pkg::t_lane_flags            i_pitch,
    input  wire fdas_pkg::t_lane_flags            i_roll,
    input  wire logic                             i_lifted,
    output fdas_pkg::t_out_word                   o_result
);

    logic [fdas_pkg::COUNTER_BITS-1:0]                     r_cnt;
    logic [fdas_pkg::COUNTER_BITS-1:0]                     n_cnt;
    logic [fdas_pkg::COUNTER_BITS-1:0]                     w_cnt_up;
    logic [fdas_pkg::CNT_OUT_W+fdas_pkg::COUNTER_BITS-1:0] w_cnt_wide;
    logic                                                  w_active;
    logic                                                  w_conf_ok;
    logic                                                  w_getups;
    logic                                                  w_ukemi;

    always_comb begin
        w_active  = !i_mode[fdas_pkg::MODE_BYPASS] && (i_req != fdas_pkg::ACT_CALIBRATE);
        w_getups  = i_mode[fdas_pkg::MODE_GETUP];
        w_ukemi   = i_mode[fdas_pkg::MODE_UKEMI];
        w_cnt_up  = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
        w_conf_ok = fdas_pkg::CNT_CMP_W'(w_cnt_up) >= fdas_pkg::CNT_CMP_W'(i_conf);

        n_cnt               = r_cnt;
        o_result.action     = i_req;
        o_result.overridden = 1'b0;
        if (w_active) begin
            if (i_pitch.fallen_lo) begin
                n_cnt               = '0;
                o_result.action     = w_getups ? fdas_pkg::ACT_GETUP_BACK
                                               : fdas_pkg::ACT_UNSTIFF;
                o_result.overridden = 1'b1;
            end else if (i_pitch.fallen_hi) begin
                n_cnt               = '0;
                o_result.action     = w_getups ? fdas_pkg::ACT_GETUP_FRONT
                                               : fdas_pkg::ACT_UNSTIFF;
                o_result.overridden = 1'b1;
            end else if (i_roll.fallen_hi || i_roll.fallen_lo) begin
                n_cnt               = '0;
                o_result.action     = fdas_pkg::ACT_TIP_OVER;
                o_result.overridden = 1'b1;
            end else if (i_pitch.ahead_hi && w_ukemi) begin
                n_cnt = w_cnt_up;
                if (w_conf_ok) begin
                    o_result.action     = fdas_pkg::ACT_UKEMI_FRONT;
                    o_result.overridden = 1'b1;
                end
            end else if (i_pitch.ahead_lo) begin
                // The counter runs even when ukemi is disabled.
                n_cnt = w_cnt_up;
                if (w_conf_ok && w_ukemi) begin
                    o_result.action     = fdas_pkg::ACT_UKEMI_BACK;
                    o_result.overridden = 1'b1;
                end
            end else if (i_roll.ahead_hi || i_roll.ahead_lo) begin
                n_cnt = w_cnt_up;
                if (w_conf_ok) begin
                    o_result.action     = fdas_pkg::ACT_UNSTIFF;
                    o_result.overridden = 1'b1;
                end
            end else if (i_lifted && (i_req != fdas_pkg::ACT_GOALIE_STAND)) begin
                n_cnt               = '0;
                o_result.action     = fdas_pkg::ACT_PICKUP;
                o_result.overridden = 1'b1;
            end else begin
                n_cnt = '0;
            end
        end
        w_cnt_wide             = (fdas_pkg::CNT_OUT_W + fdas_pkg::COUNTER_BITS)'(n_cnt);
        o_result.falling_count = w_cnt_wide[fdas_pkg::CNT_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_commit) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fall_detect_action_select.sv =====
// Fall detection and safety action selection.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one sensor frame
// per word: eight foot pressures, roll and pitch angle and rate, and the
// requested action. Output channel (o_out_valid / i_out_ready / o_out_word)
// returns one word per frame: the final action, an override flag and the
// consecutive falling frame count.
// Configuration channel (i_cfg_valid / o_cfg_ready, index and data) is always
// ready; the user must see that it is written only while the block is idle,
// and the block itself does not enforce this. An accepted frame passes
// through stage one, stage two and the output register. A new frame cannot
// enter stage two until the previous frame has committed its new weight in the
// output stage, as the weight filter forms its product from the stored weight.
// Reset loads the default limits, sets the filtered weight to 5.0 kg, clears
// the fall counter and empties the pipeline.
// When the receiver stalls, the output register holds its word, one more
// frame can wait in each of the two internal stages, and then o_in_ready drops.
`default_nettype none

module fall_detect_action_select (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire fdas_pkg::t_in_word                   i_in_word,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output fdas_pkg::t_out_word                       o_out_word,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [fdas_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [fdas_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [fdas_pkg::THR_W-1:0]  r_fallen_thr;
    logic [fdas_pkg::THR_W-1:0]  r_fwd_thr;
    logic [fdas_pkg::THR_W-1:0]  r_back_thr;
    logic [fdas_pkg::THR_W-1:0]  r_side_thr;
    logic [fdas_pkg::LOOK_W-1:0] r_look;
    logic [fdas_pkg::THR_W-1:0]  r_min_weight;
    logic [fdas_pkg::CONF_W-1:0] r_confirm;
    logic [fdas_pkg::MODE_W-1:0] r_mode;

    // Pipeline control.
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic w_in_accept;
    logic w_s2_load;
    logic w_commit;

    // Stage payloads.
    logic [fdas_pkg::ACT_W-1:0] r_s1_req;
    logic                       r_s1_pvalid;
    logic [fdas_pkg::ACT_W-1:0] r_s2_req;
    logic                       r_s2_pvalid;
    fdas_pkg::t_lane_flags      w_pitch_flags;
    fdas_pkg::t_lane_flags      w_roll_flags;
    fdas_pkg::t_lane_flags      r_s2_pitch;
    fdas_pkg::t_lane_flags      r_s2_roll;
    fdas_pkg::t_weight_ctl      w_weight_ctl;
    fdas_pkg::t_out_word        w_result;
    fdas_pkg::t_out_word        r_out;
    logic                       w_lifted;
    logic                       w_s2_active;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallen_thr <= 15'd3574;
            r_fwd_thr    <= 15'd2860;
            r_back_thr   <= 15'd2502;
            r_side_thr   <= 15'd3217;
            r_look       <= 10'd205;
            r_min_weight <= 15'd141;
            r_confirm    <= 8'd3;
            r_mode       <= 3'd6;
        end else if (i_cfg_valid) begin
            case (fdas_pkg::t_cfg_idx'(i_cfg_index))
                fdas_pkg::CFG_FALLEN:     r_fallen_thr <= i_cfg_data[fdas_pkg::THR_W-1:0];
                fdas_pkg::CFG_FWD:        r_fwd_thr    <= i_cfg_data[fdas_pkg::THR_W-1:0];
                fdas_pkg::CFG_BACK:       r_back_thr   <= i_cfg_data[fdas_pkg::THR_W-1:0];
                fdas_pkg::CFG_SIDE:       r_side_thr   <= i_cfg_data[fdas_pkg::THR_W-1:0];
                fdas_pkg::CFG_LOOK:       r_look       <= i_cfg_data[fdas_pkg::LOOK_W-1:0];
                fdas_pkg::CFG_MIN_WEIGHT: r_min_weight <= i_cfg_data[fdas_pkg::THR_W-1:0];
                fdas_pkg::CFG_CONFIRM:    r_confirm    <= i_cfg_data[fdas_pkg::CONF_W-1:0];
                fdas_pkg::CFG_MODE:       r_mode       <= i_cfg_data[fdas_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage two only loads when it is empty, so the weight product always
    // sees the weight left by the frame before.
    always_comb begin
        w_commit    = r_s2_valid && (!r_out_valid || i_out_ready);
        w_s2_load   = r_s1_valid && !r_s2_valid;
        o_in_ready  = !r_s1_valid || w_s2_load;
        w_in_accept = i_in_valid && o_in_ready;
        w_s2_active = !r_mode[fdas_pkg::MODE_BYPASS]
                      && (r_s2_req != fdas_pkg::ACT_CALIBRATE);
        w_weight_ctl.in_load   = w_in_accept;
        w_weight_ctl.prod_load = w_s2_load;
        w_weight_ctl.commit    = w_commit;
        w_weight_ctl.update    = w_s2_active && r_s2_pvalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s2_load) begin
                r_s2_valid <= 1'b1;
            end else if (w_commit) begin
                r_s2_valid <= 1'b0;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_req    <= i_in_word.requested_action;
            r_s1_pvalid <= i_in_word.pressures_valid;
        end
        if (w_s2_load) begin
            r_s2_req    <= r_s1_req;
            r_s2_pvalid <= r_s1_pvalid;
            r_s2_pitch  <= w_pitch_flags;
            r_s2_roll   <= w_roll_flags;
        end
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    // Pitch lane: forward and backward limits differ.
    fdas_lane u_pitch_lane (
        .i_clk        (i_clk),
        .i_load       (w_in_accept),
        .i_angle      (i_in_word.pitch_angle),
        .i_rate       (i_in_word.pitch_rate),
        .i_look       (r_look),
        .i_fallen_thr (r_fallen_thr),
        .i_hi_thr     (r_fwd_thr),
        .i_lo_thr     (r_back_thr),
        .o_flags      (w_pitch_flags)
    );

    // Roll lane: the sideways limit applies both ways.
    fdas_lane u_roll_lane (
        .i_clk        (i_clk),
        .i_load       (w_in_accept),
        .i_angle      (i_in_word.roll_angle),
        .i_rate       (i_in_word.roll_rate),
        .i_look       (r_look),
        .i_fallen_thr (r_fallen_thr),
        .i_hi_thr     (r_side_thr),
        .i_lo_thr     (r_side_thr),
        .o_flags      (w_roll_flags)
    );

    fdas_weight u_weight (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_weight_ctl),
        .i_left       (i_in_word.left_foot_pressures),
        .i_right      (i_in_word.right_foot_pressures),
        .i_min_weight (r_min_weight),
        .o_lifted     (w_lifted)
    );

    fdas_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (w_commit),
        .i_req    (r_s2_req),
        .i_mode   (r_mode),
        .i_conf   (r_confirm),
        .i_pitch  (r_s2_pitch),
        .i_roll   (r_s2_roll),
        .i_lifted (w_lifted),
        .o_result (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // A bypassed or calibrate frame is never overridden.
    a_bypass_no_override: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !w_s2_active) |-> !w_result.overridden)
        else $error("bypassed frame was overridden");

    // Fallen and pickup decisions always clear the counter.
    a_fallen_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_result.overridden
         && (w_result.action == fdas_pkg::ACT_GETUP_BACK
             || w_result.action == fdas_pkg::ACT_GETUP_FRONT
             || w_result.action == fdas_pkg::ACT_TIP_OVER
             || w_result.action == fdas_pkg::ACT_PICKUP))
        |-> (w_result.falling_count == '0))
        else $error("fallen or pickup decision left the counter set");

    // Ukemi is only chosen when it is enabled.
    a_ukemi_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_result.overridden
         && (w_result.action == fdas_pkg::ACT_UKEMI_FRONT
             || w_result.action == fdas_pkg::ACT_UKEMI_BACK))
        |-> r_mode[fdas_pkg::MODE_UKEMI])
        else $error("ukemi chosen while disabled");

    // The output register is loaded next cycle after a commit.
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_out_valid && (o_out_word == $past(w_result))))
        else $error("committed word not presented");

endmodule

`default_nettype wire

// ===== bench/fall_action_checker.sv =====
`timescale 1ns / 1ps

// Watches the frame, result and register channels of the fall detector and
// predicts every result word from the frames accepted at its input.
module fall_action_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_ready,
    input  wire fdas_pkg::t_in_word              i_in_word,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_ready,
    input  wire fdas_pkg::t_out_word             i_out_word,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [fdas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fdas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                   o_failures,
    output int                                   o_pending
);

    import fdas_pkg::*;

    t_out_word               predicted_actions [$];
    t_out_word               oldest;
    logic [THR_W-1:0]        limits [8];
    logic [WEIGHT_W-1:0]     weight_est;
    logic [COUNTER_BITS-1:0] fall_run;
    int                      mismatches = 0;
    int                      waiting = 0;

    assign o_failures = mismatches;
    assign o_pending  = waiting;

    // Works out the result word of one frame and advances the weight filter
    // and the falling run length.
    function automatic t_out_word judge_frame(input t_in_word w);
        t_out_word         r;
        logic [MODE_W-1:0] mode;
        longint            roll, pitch, froll, fpitch, look;
        longint            fallen, fwd, back_lim, side;
        logic [63:0]       press_sum, acc;
        logic [CHAN_W-1:0] ch;
        int                k;
        mode = limits[CFG_MODE][MODE_W-1:0];
        r.action = w.requested_action;
        r.overridden = 1'b0;
        if (!mode[MODE_BYPASS] && w.requested_action != ACT_CALIBRATE) begin
            roll     = longint'($signed(w.roll_angle));
            pitch    = longint'($signed(w.pitch_angle));
            look     = longint'(limits[CFG_LOOK]);
            froll    = roll * 1024 + longint'($signed(w.roll_rate)) * look;
            fpitch   = pitch * 1024 + longint'($signed(w.pitch_rate)) * look;
            fallen   = longint'(limits[CFG_FALLEN]);
            fwd      = longint'(limits[CFG_FWD]) * 1024;
            back_lim = longint'(limits[CFG_BACK]) * 1024;
            side     = longint'(limits[CFG_SIDE]) * 1024;
            if (w.pressures_valid) begin
                press_sum = '0;
                for (k = 0; k < PRESSURE_CHANNELS; k++) begin
                    if (k < 4) begin
                        ch = w.left_foot_pressures[CHAN_W*k +: CHAN_W];
                    end else begin
                        ch = w.right_foot_pressures[CHAN_W*(k-4) +: CHAN_W];
                    end
                    press_sum += 64'(ch);
                end
                // Gain of about 0.2 on the new sum, kg * 65536.
                acc = 64'(weight_est) * 64'd52429 + (press_sum << 8) * 64'd13107;
                weight_est = acc[16 +: WEIGHT_W];
            end
            if (pitch < -fallen) begin
                fall_run = '0;
                r.action = mode[MODE_GETUP] ? ACT_GETUP_BACK : ACT_UNSTIFF;
                r.overridden = 1'b1;
            end else if (pitch > fallen) begin
                fall_run = '0;
                r.action = mode[MODE_GETUP] ? ACT_GETUP_FRONT : ACT_UNSTIFF;
                r.overridden = 1'b1;
            end else if (roll > fallen || roll < -fallen) begin
                fall_run = '0;
                r.action = ACT_TIP_OVER;
                r.overridden = 1'b1;
            end else if (fpitch > fwd && mode[MODE_UKEMI]) begin
                if (fall_run != '1) fall_run = fall_run + 1'b1;
                if (fall_run >= limits[CFG_CONFIRM]) begin
                    r.action = ACT_UKEMI_FRONT;
                    r.overridden = 1'b1;
                end
            end else if (fpitch < -back_lim) begin
                if (fall_run != '1) fall_run = fall_run + 1'b1;
                if (fall_run >= limits[CFG_CONFIRM] && mode[MODE_UKEMI]) begin
                    r.action = ACT_UKEMI_BACK;
                    r.overridden = 1'b1;
                end
            end else if (froll > side || froll < -side) begin
                if (fall_run != '1) fall_run = fall_run + 1'b1;
                if (fall_run >= limits[CFG_CONFIRM]) begin
                    r.action = ACT_UNSTIFF;
                    r.overridden = 1'b1;
                end
            end else if (32'(weight_est) < (32'(limits[CFG_MIN_WEIGHT]) << 8)
                         && w.requested_action != ACT_GOALIE_STAND) begin
                fall_run = '0;
                r.action = ACT_PICKUP;
                r.overridden = 1'b1;
            end else begin
                fall_run = '0;
            end
        end
        r.falling_count = CNT_OUT_W'(fall_run);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limits[CFG_FALLEN]     = 15'd3574;
            limits[CFG_FWD]        = 15'd2860;
            limits[CFG_BACK]       = 15'd2502;
            limits[CFG_SIDE]       = 15'd3217;
            limits[CFG_LOOK]       = 15'd205;
            limits[CFG_MIN_WEIGHT] = 15'd141;
            limits[CFG_CONFIRM]    = 15'd3;
            limits[CFG_MODE]       = 15'd6;
            weight_est = 24'd327680;
            fall_run = '0;
            predicted_actions.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LOOK:    limits[CFG_LOOK]    = THR_W'(i_cfg_data[LOOK_W-1:0]);
                    CFG_CONFIRM: limits[CFG_CONFIRM] = THR_W'(i_cfg_data[CONF_W-1:0]);
                    CFG_MODE:    limits[CFG_MODE]    = THR_W'(i_cfg_data[MODE_W-1:0]);
                    default:     limits[i_cfg_index] = i_cfg_data;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_actions.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with none expected, got action %0d", $time,
                             i_out_word.action);
                end else begin
                    oldest = predicted_actions.pop_front();
                    if (oldest.action !== i_out_word.action) begin
                        mismatches++;
                        $display("%0t: action expected %0d, got %0d", $time,
                                 oldest.action, i_out_word.action);
                    end
                    if (oldest.overridden !== i_out_word.overridden) begin
                        mismatches++;
                        $display("%0t: overridden expected %0d, got %0d", $time,
                                 oldest.overridden, i_out_word.overridden);
                    end
                    if (oldest.falling_count !== i_out_word.falling_count) begin
                        mismatches++;
                        $display("%0t: falling_count expected %0d, got %0d", $time,
                                 oldest.falling_count, i_out_word.falling_count);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_actions.push_back(judge_frame(i_in_word));
            end
        end
        waiting = predicted_actions.size();
    end

endmodule

// ===== bench/fall_detect_action_select_test.sv =====
`timescale 1ns / 1ps

// Top of the fall detector bench. It makes the stimulus (sensor frames and
// register writes), drives the ready of the result channel, and gives the
// verdict. All prediction and comparison lives in the checker beside the block.
module fall_detect_action_select_test;

    import fdas_pkg::*;

    // Kinds of frame that the random traffic is built from.
    typedef enum {
        SC_QUIET,
        SC_FALL_BACK,
        SC_FALL_FRONT,
        SC_FALL_SIDE,
        SC_AHEAD_FWD,
        SC_AHEAD_BACK,
        SC_AHEAD_SIDE,
        SC_LIFTED,
        SC_NOISE
    } t_scene;

    localparam int RAND_PER_PHASE = 90;
    localparam int SATURATE_RUN   = 300;
    localparam int HOLD_CYCLES    = 60;
    localparam int PHASES         = 8;

    // Request codes that the block passes on untouched.
    localparam logic [ACT_W-1:0] ACT_PLAIN   = '0;
    localparam logic [ACT_W-1:0] ACT_TOPMOST = '1;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            frame_valid = 1'b0;
    t_in_word        frame_word = '0;
    logic            frame_ready;
    logic            result_valid;
    logic            result_ready = 1'b0;
    t_out_word       result_word;
    logic            reg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  reg_index = '0;
    logic [CFG_DATA_W-1:0] reg_data = '0;
    logic            reg_ready;
    int              failures;
    int              pending;

    // Idle rates in percent: of taken frames for the sender, of cycles for the receiver.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_wanted = 1'b0;

    // The fallen limit as last written; the frame maker places angles around it.
    int fallen_lim = 3574;

    fall_detect_action_select dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (frame_valid),
        .o_in_ready  (frame_ready),
        .i_in_word   (frame_word),
        .o_out_valid (result_valid),
        .i_out_ready (result_ready),
        .o_out_word  (result_word),
        .i_cfg_valid (reg_valid),
        .o_cfg_ready (reg_ready),
        .i_cfg_index (reg_index),
        .i_cfg_data  (reg_data)
    );

    fall_action_checker action_watch (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (frame_valid),
        .i_in_ready  (frame_ready),
        .i_in_word   (frame_word),
        .i_out_valid (result_valid),
        .i_out_ready (result_ready),
        .i_out_word  (result_word),
        .i_cfg_valid (reg_valid),
        .i_cfg_ready (reg_ready),
        .i_cfg_index (reg_index),
        .i_cfg_data  (reg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Hard limit on the run; a correct run ends far earlier.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side. Ready changes only at the falling edge. When a long hold is
    // asked for, ready is held low once while the sender keeps offering, so the
    // block fills and drops its input ready.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_wanted && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end else begin
                result_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
            end
        end
    end

    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    // Four 12-bit pressure channels of one foot, each in lo..hi.
    function automatic logic [FOOT_W-1:0] foot_load(input int lo, input int hi);
        logic [FOOT_W-1:0] f;
        int                k;
        for (k = 0; k < 4; k++) begin
            f[CHAN_W*k +: CHAN_W] = CHAN_W'(span(lo, hi));
        end
        return f;
    endfunction

    // Requests lean toward calibrate, goalie stand and the codes the block
    // itself can pick, so that "assigned equals requested" shows up.
    function automatic logic [ACT_W-1:0] pick_request();
        int r;
        r = $urandom_range(99, 0);
        if (r < 10) return ACT_CALIBRATE;
        if (r < 20) return ACT_GOALIE_STAND;
        if (r < 40) return ACT_W'(span(int'(ACT_GETUP_BACK), int'(ACT_PICKUP)));
        return ACT_W'($urandom_range(63, 0));
    endfunction

    // Builds one frame of the given kind. A quiet frame stands upright on both
    // feet; the others push one axis past the fallen limit, give a gyro rate
    // large enough to predict a fall, take the weight off the feet, or are
    // plain noise over every bit.
    function automatic t_in_word make_frame(input t_scene sc);
        t_in_word     w;
        logic [191:0] noise;
        int           calm;
        calm = fallen_lim / 4;
        w.left_foot_pressures  = foot_load(96, 640);
        w.right_foot_pressures = foot_load(96, 640);
        w.pressures_valid      = ($urandom_range(9, 0) != 0);
        w.roll_angle           = 16'(span(-calm, calm));
        w.pitch_angle          = 16'(span(-calm, calm));
        w.roll_rate            = 16'(span(-300, 300));
        w.pitch_rate           = 16'(span(-300, 300));
        w.requested_action     = pick_request();
        case (sc)
            SC_FALL_BACK: begin
                w.pitch_angle = 16'(span(-32768, -fallen_lim - 1));
            end
            SC_FALL_FRONT: begin
                w.pitch_angle = (fallen_lim < 32767) ? 16'(span(fallen_lim + 1, 32767))
                                                     : 16'sh7FFF;
            end
            SC_FALL_SIDE: begin
                if ($urandom_range(1, 0) != 0) begin
                    w.roll_angle = 16'(span(-32768, -fallen_lim - 1));
                end else if (fallen_lim < 32767) begin
                    w.roll_angle = 16'(span(fallen_lim + 1, 32767));
                end
            end
            SC_AHEAD_FWD: begin
                w.pitch_rate = 16'(span(20000, 32767));
            end
            SC_AHEAD_BACK: begin
                w.pitch_rate = 16'(span(-32768, -20000));
            end
            SC_AHEAD_SIDE: begin
                w.roll_rate = ($urandom_range(1, 0) != 0) ? 16'(span(20000, 32767))
                                                          : 16'(span(-32768, -20000));
            end
            SC_LIFTED: begin
                w.left_foot_pressures  = foot_load(0, 6);
                w.right_foot_pressures = foot_load(0, 6);
            end
            SC_NOISE: begin
                noise = {$urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom()};
                w = noise[$bits(t_in_word)-1:0];
            end
            default: ;
        endcase
        return w;
    endfunction

    // Drops valid for the given number of cycles.
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        frame_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Offers one frame word and waits until it is taken. Valid stays high
    // afterwards unless the sender decides to idle, so back-to-back words keep
    // valid up without a drop.
    task automatic offer_frame(input t_in_word w);
        @(negedge clk);
        frame_valid <= 1'b1;
        frame_word  <= w;
        do @(posedge clk); while (!frame_ready);
        if ($urandom_range(99, 0) < sender_idle_pct) begin
            pause_sender($urandom_range(3, 1));
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        reg_valid <= 1'b1;
        reg_index <= idx;
        reg_data  <= value;
        do @(posedge clk); while (!reg_ready);
        @(negedge clk);
        reg_valid <= 1'b0;
        if (idx == CFG_FALLEN) fallen_lim = int'(value);
    endtask

    // Waits until every predicted word has come back, then lets the clock run on
    // so that nothing is in flight when the registers change.
    task automatic wait_drained();
        pause_sender(1);
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // One register setting per phase; the extremes of every register appear.
    task automatic apply_setting(input int phase);
        logic [CFG_DATA_W-1:0] v [8];
        int                    i;
        v[CFG_FALLEN]     = 15'd3574;
        v[CFG_FWD]        = 15'd2860;
        v[CFG_BACK]       = 15'd2502;
        v[CFG_SIDE]       = 15'd3217;
        v[CFG_LOOK]       = 15'd205;
        v[CFG_MIN_WEIGHT] = 15'd141;
        v[CFG_CONFIRM]    = 15'd3;
        v[CFG_MODE]       = 15'd6;
        case (phase)
            1: begin
                // Getups without ukemi, longest horizon, every robot looks lifted.
                v[CFG_MODE]       = 15'd2;
                v[CFG_LOOK]       = 15'd1023;
                v[CFG_CONFIRM]    = 15'd1;
                v[CFG_MIN_WEIGHT] = 15'd32767;
            end
            2: begin
                // All limits at zero, no horizon, the slowest confirmation.
                v[CFG_FALLEN]     = '0;
                v[CFG_FWD]        = '0;
                v[CFG_BACK]       = '0;
                v[CFG_SIDE]       = '0;
                v[CFG_LOOK]       = '0;
                v[CFG_MIN_WEIGHT] = '0;
                v[CFG_CONFIRM]    = 15'd255;
                v[CFG_MODE]       = '0;
            end
            3: begin
                // Bypass with the limits at their top.
                v[CFG_FALLEN] = 15'd32767;
                v[CFG_FWD]    = 15'd32767;
                v[CFG_BACK]   = 15'd32767;
                v[CFG_SIDE]   = 15'd32767;
                v[CFG_LOOK]   = 15'd1023;
                v[CFG_MODE]   = 15'd1;
            end
            4: begin
                // Ukemi only, and a confirmation count of zero.
                v[CFG_FALLEN]     = 15'($urandom_range(32767, 0));
                v[CFG_FWD]        = 15'($urandom_range(32767, 0));
                v[CFG_BACK]       = 15'($urandom_range(32767, 0));
                v[CFG_SIDE]       = 15'($urandom_range(32767, 0));
                v[CFG_LOOK]       = 15'd512;
                v[CFG_MIN_WEIGHT] = 15'($urandom_range(600, 0));
                v[CFG_CONFIRM]    = '0;
                v[CFG_MODE]       = 15'd4;
            end
            5: begin
                v[CFG_FALLEN]     = 15'(span(1000, 6000));
                v[CFG_FWD]        = 15'(span(1000, 6000));
                v[CFG_BACK]       = 15'(span(1000, 6000));
                v[CFG_SIDE]       = 15'(span(1000, 6000));
                v[CFG_LOOK]       = 15'($urandom_range(1023, 0));
                v[CFG_MIN_WEIGHT] = 15'($urandom_range(400, 0));
                v[CFG_CONFIRM]    = 15'(span(1, 8));
            end
            6: begin
                // Full-width data, so the bits above the narrow registers move too.
                for (i = 0; i < 8; i++) begin
                    v[i] = 15'($urandom_range(32767, 0));
                end
            end
            7: begin
                v[CFG_MODE] = 15'd7;
            end
            default: ;
        endcase
        for (i = 0; i < 8; i++) begin
            write_reg(t_cfg_idx'(i), v[i]);
        end
    endtask

    // Random traffic made of short runs of one kind of frame, so that falls
    // are predicted for several frames in a row and the weight filter has
    // time to settle when the feet leave the ground.
    task automatic random_traffic(input int n_items);
        int     sent;
        int     r;
        int     len;
        t_scene sc;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99, 0);
            if (r < 25) begin
                sc = SC_QUIET;
                len = span(1, 3);
            end else if (r < 31) begin
                sc = SC_FALL_BACK;
                len = span(1, 2);
            end else if (r < 35) begin
                sc = SC_FALL_FRONT;
                len = span(1, 2);
            end else if (r < 39) begin
                sc = SC_FALL_SIDE;
                len = span(1, 2);
            end else if (r < 51) begin
                sc = SC_AHEAD_FWD;
                len = span(1, 6);
            end else if (r < 63) begin
                sc = SC_AHEAD_BACK;
                len = span(1, 6);
            end else if (r < 75) begin
                sc = SC_AHEAD_SIDE;
                len = span(1, 6);
            end else if (r < 87) begin
                sc = SC_LIFTED;
                len = span(4, 14);
            end else begin
                sc = SC_NOISE;
                len = span(1, 2);
            end
            repeat (len) offer_frame(make_frame(sc));
            sent += len;
        end
    endtask

    initial begin
        t_in_word w;
        int       i;
        int       phase;

        // Reset is held, then released at a falling edge.
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames, reset settings. First the feet leave the ground:
        // the filtered weight decays from 5 kg until it passes the lifted
        // limit, once with a goalie stand request that must not be picked up.
        for (i = 0; i < 11; i++) begin
            w = make_frame(SC_LIFTED);
            w.left_foot_pressures  = '0;
            w.right_foot_pressures = '0;
            w.pressures_valid      = 1'b1;
            w.requested_action     = (i == 9) ? ACT_GOALIE_STAND : ACT_PLAIN;
            offer_frame(w);
        end
        w = make_frame(SC_QUIET);
        w.requested_action = ACT_PLAIN;
        offer_frame(w);

        // Fallen back under a calibrate request (nothing may change), then
        // fallen back, front and to the side at the extreme angles.
        w = make_frame(SC_QUIET);
        w.pitch_angle = 16'sh8000;
        w.requested_action = ACT_CALIBRATE;
        offer_frame(w);
        w.requested_action = ACT_TOPMOST;
        offer_frame(w);
        w.pitch_angle = 16'sh7FFF;
        offer_frame(w);
        w.pitch_angle = '0;
        w.roll_angle  = 16'sh8000;
        offer_frame(w);

        // Predicted falls at the extreme rates: forward, backward and sideways,
        // three frames each, so the run length passes the confirmation count.
        for (i = 0; i < 9; i++) begin
            w = make_frame(SC_QUIET);
            w.requested_action = ACT_PLAIN;
            w.roll_angle  = '0;
            w.pitch_angle = '0;
            w.roll_rate   = '0;
            w.pitch_rate  = '0;
            if (i < 3) begin
                w.pitch_rate = 16'sh7FFF;
            end else if (i < 6) begin
                w.pitch_rate = 16'sh8000;
            end else begin
                w.roll_rate = (i % 2 == 0) ? 16'sh7FFF : 16'sh8000;
            end
            offer_frame(w);
        end

        // Full-scale pressures, first flagged invalid so the filter must hold.
        w = make_frame(SC_QUIET);
        w.left_foot_pressures  = '1;
        w.right_foot_pressures = '1;
        w.pressures_valid      = 1'b0;
        offer_frame(w);
        w.pressures_valid = 1'b1;
        offer_frame(w);

        // Random phases, each with its own settings and idle pattern.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            apply_setting(phase);
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 48;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 48;
                end
                default: begin
                    sender_idle_pct = 34;
                    receiver_stall_pct = 34;
                end
            endcase
            if (phase == 1) hold_wanted = 1'b1;
            // A long run of forward predictions drives the run length into
            // saturation, with room for the calibrate frames that hold it.
            if (phase == 0) repeat (SATURATE_RUN) offer_frame(make_frame(SC_AHEAD_FWD));
            random_traffic(RAND_PER_PHASE);
        end

        wait_drained();
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
